@@ src/hrkeg_pkg.sv @@
package hrkeg_pkg;

  localparam int SLOTS   = 6;
  localparam int STEPS   = 2 * SLOTS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int STEP_W  = $clog2(STEPS);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W = 2;

  typedef logic [7:0]  code_t;
  typedef logic [31:0] tick_t;
  typedef logic [15:0] ticks16_t;

  localparam code_t CODE_EMPTY     = 8'd0;
  localparam code_t CODE_ROLLOVER  = 8'd1;
  localparam code_t CODE_POST_FAIL = 8'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_RATE  = 2'd1;

  typedef enum logic [2:0] {
    KIND_POST_FAIL = 3'd0,
    KIND_ROLLOVER  = 3'd1,
    KIND_DOWN      = 3'd2,
    KIND_HOLD      = 3'd3,
    KIND_UP        = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_EVAL,
    B_SCAN
  } back_state_t;

  // one classified report as it travels from front to back
  typedef struct packed {
    code_t [SLOTS-1:0] cur;
    code_t [SLOTS-1:0] prev;
    tick_t             now;
    logic [SLOTS-1:0]  up_mask;
    logic [SLOTS-1:0]  keep_mask;
    logic [SLOTS-1:0]  down_mask;
    logic              err;
    event_kind_t       err_kind;
  } report_t;

endpackage

@@ src/hrkeg_front.sv @@
module hrkeg_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  hrkeg_pkg::code_t [hrkeg_pkg::SLOTS-1:0] codes,
  input  hrkeg_pkg::tick_t                       now_tick,
  input  logic                                   q_full,
  output logic                                   q_push,
  output hrkeg_pkg::report_t                     q_word
);
  import hrkeg_pkg::*;

  code_t [SLOTS-1:0] prev_r, prev_nxt;
  logic              err;
  event_kind_t       err_kind;
  logic [SLOTS-1:0]  present, seen;

  // first error slot wins: scan from the top so the lowest index lands last
  always_comb begin
    err      = 1'b0;
    err_kind = KIND_ROLLOVER;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (codes[i] == CODE_POST_FAIL) begin
        err      = 1'b1;
        err_kind = KIND_POST_FAIL;
      end else if (codes[i] == CODE_ROLLOVER) begin
        err      = 1'b1;
        err_kind = KIND_ROLLOVER;
      end
    end
  end

  always_comb begin
    present = '0;
    seen    = '0;
    for (int i = 0; i < SLOTS; i++) begin
      for (int j = 0; j < SLOTS; j++) begin
        if (codes[j] == prev_r[i]) present[i] = 1'b1;
        if (prev_r[j] == codes[i]) seen[i] = 1'b1;
      end
    end
  end

  always_comb begin
    q_word.cur      = codes;
    q_word.prev     = prev_r;
    q_word.now      = now_tick;
    q_word.err      = err;
    q_word.err_kind = err_kind;
    for (int i = 0; i < SLOTS; i++) begin
      q_word.up_mask[i]   = (prev_r[i] != CODE_EMPTY) && !present[i];
      q_word.keep_mask[i] = (prev_r[i] != CODE_EMPTY) && present[i];
      q_word.down_mask[i] = (codes[i] != CODE_EMPTY) && !seen[i];
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // error reports leave the previous report untouched
  assign prev_nxt = (q_push && !err) ? codes : prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

@@ src/hrkeg_queue.sv @@
module hrkeg_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hrkeg_pkg::report_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output hrkeg_pkg::report_t head_word
);
  import hrkeg_pkg::*;

  report_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_word  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ src/hrkeg_back.sv @@
module hrkeg_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [hrkeg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  hrkeg_pkg::ticks16_t                   cfg_data,
  input  logic                                  head_valid,
  input  hrkeg_pkg::report_t                    head_word,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            out_event_kind,
  output hrkeg_pkg::code_t                      out_event_code,
  output logic                                  out_last_of_report
);
  import hrkeg_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [SLOTS-1:0]   hold_mask_r, hold_mask_nxt;
  ticks16_t           hold_delay_r, hold_rate_r;
  tick_t              press_r [SLOTS];
  ticks16_t           cd_r [SLOTS];
  code_t              remembered_r [SLOTS];

  logic               out_valid_r;
  event_kind_t        out_kind_r;
  code_t              out_code_r;
  logic               out_last_r;

  logic               out_free;
  logic [STEPS-1:0]   ev_mask;
  logic               step_ev, later_ev, last_step;
  logic [SLOT_W-1:0]  slot;
  logic               in_prev_phase;
  logic               load;
  event_kind_t        load_kind;
  code_t              load_code;
  logic               load_last;
  logic               step_go;

  assign out_free      = !out_valid_r || out_ready;
  assign ev_mask       = {head_word.down_mask, head_word.up_mask | hold_mask_r};
  assign in_prev_phase = (step_r < STEP_W'(SLOTS));
  assign slot          = in_prev_phase ? step_r[SLOT_W-1:0]
                                       : SLOT_W'(step_r - STEP_W'(SLOTS));
  assign step_ev       = ev_mask[step_r];
  assign last_step     = (step_r == STEP_W'(STEPS - 1));

  always_comb begin
    later_ev = 1'b0;
    for (int j = 0; j < STEPS; j++) begin
      if (STEP_W'(j) > step_r) later_ev = later_ev | ev_mask[j];
    end
  end

  // hold check for every kept key, done once per report
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hold_mask_nxt[i] = head_word.keep_mask[i] &&
                         ((head_word.now - press_r[i]) >= {16'd0, cd_r[i]});
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      B_IDLE: begin
        if (head_valid) state_nxt = B_EVAL;
      end
      B_EVAL: begin
        step_nxt = '0;
        if (head_word.err) begin
          if (out_free) state_nxt = B_IDLE;
        end else begin
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        if (!step_ev || out_free) begin
          if (last_step) state_nxt = B_IDLE;
          else           step_nxt  = step_r + 1'b1;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    load      = 1'b0;
    pop       = 1'b0;
    step_go   = 1'b0;
    load_kind = KIND_UP;
    load_code = CODE_EMPTY;
    load_last = 1'b0;
    case (state_r)
      B_EVAL: begin
        if (head_word.err && out_free) begin
          load      = 1'b1;
          pop       = 1'b1;
          load_kind = head_word.err_kind;
          load_last = 1'b1;
        end
      end
      B_SCAN: begin
        step_go   = !step_ev || out_free;
        load      = step_ev && out_free;
        pop       = step_go && last_step;
        load_last = !later_ev;
        if (!in_prev_phase) begin
          load_kind = KIND_DOWN;
          load_code = head_word.cur[slot];
        end else if (head_word.up_mask[slot]) begin
          load_kind = KIND_UP;
          load_code = remembered_r[slot];
        end else begin
          load_kind = KIND_HOLD;
          load_code = head_word.prev[slot];
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      step_r       <= '0;
      hold_mask_r  <= '0;
      hold_delay_r <= 16'd500;
      hold_rate_r  <= 16'd50;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        press_r[i]      <= '0;
        cd_r[i]         <= '0;
        remembered_r[i] <= CODE_EMPTY;
      end
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (state_r == B_EVAL) hold_mask_r <= hold_mask_nxt;
      if (cfg_we && cfg_index == CFG_HOLD_DELAY) hold_delay_r <= cfg_data;
      if (cfg_we && cfg_index == CFG_HOLD_RATE)  hold_rate_r  <= cfg_data;
      if (load)           out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (load && state_r == B_SCAN && load_kind != KIND_UP) begin
        press_r[slot]      <= head_word.now;
        remembered_r[slot] <= load_code;
        cd_r[slot]         <= in_prev_phase ? hold_rate_r : hold_delay_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= load_kind;
      out_code_r <= load_code;
      out_last_r <= load_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = out_kind_r;
  assign out_event_code     = out_code_r;
  assign out_last_of_report = out_last_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_SCAN |-> step_r <= STEP_W'(STEPS - 1))
    else $error("scan step out of range");

  a_pop_only_with_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop without a queued report");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EVAL && head_word.err && out_free) |=> state_r == B_IDLE)
    else $error("error report did not retire after one word");

  a_load_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    (load && state_r == B_SCAN) |-> ev_mask[step_r])
    else $error("word emitted for a step without an event");

  a_no_load_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("output register overwritten while stalled");

endmodule

@@ src/hid_report_key_event_generator.sv @@
// Keyboard report differencer with key repeat. Each input word is one boot
// keyboard report (six key slots plus a tick count); the block emits a burst
// of key event words: one error word for a report that carries the rollover
// or post-fail code, otherwise up and hold words for the previous slots in
// order, then down words for the new slots, with last_of_report on the final
// word. A report with no events gives no words. The front end classifies a
// report in the cycle it is accepted and drops it into a two-entry queue; the
// report being walked stays at the head, so one more report can wait behind
// it while a burst drains. The back end picks up the queue head in its idle
// state, does the hold timing check in its eval state and then walks twelve
// slot steps, one per cycle, a step with an event waiting while the output
// stalls; an error report gets its word in the eval state. The output word is
// registered, so steps with no event move on while a word waits, and a new
// word loads in the cycle the old one is taken. hold_delay (index 0) and
// hold_rate (index 1) are written through the cfg port, other indexes ignored;
// the user writes them only while the block is idle, which it does not check.
module hid_report_key_event_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [hrkeg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data,
  // report words in
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_slot0_code,
  input  logic [7:0]                          in_slot1_code,
  input  logic [7:0]                          in_slot2_code,
  input  logic [7:0]                          in_slot3_code,
  input  logic [7:0]                          in_slot4_code,
  input  logic [7:0]                          in_slot5_code,
  input  logic [31:0]                         in_now_tick,
  // event words out
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [2:0]                          out_event_kind,
  output logic [7:0]                          out_event_code,
  output logic                                out_last_of_report
);
  import hrkeg_pkg::*;

  code_t [SLOTS-1:0] codes;
  logic              q_full, q_push, q_pop, head_valid;
  report_t           push_word, head_word;

  // slot ports gathered into one vector, slot 0 lowest
  assign codes = {in_slot5_code, in_slot4_code, in_slot3_code,
                  in_slot2_code, in_slot1_code, in_slot0_code};

  // classify and track the previous report
  hrkeg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .codes    (codes),
    .now_tick (in_now_tick),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (push_word)
  );

  // short buffer so front and back stall independently
  hrkeg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_word  (push_word),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  // per-slot timing state and the event sequencer
  hrkeg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .head_valid         (head_valid),
    .head_word          (head_word),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_event_code     (out_event_code),
    .out_last_of_report (out_last_of_report)
  );

endmodule

@@ tb/tb_hid_report_key_event_generator.sv @@
module tb_hid_report_key_event_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import hrkeg_pkg::*;

  // one report as the driver sees it: slot 0 leftmost
  typedef code_t [0:SLOTS-1] slots_t;

  typedef struct packed {
    event_kind_t kind;
    code_t       code;
    logic        last;
  } key_event_t;

  // directed row: report word plus an optional typed-in event
  typedef struct packed {
    slots_t     slots;
    tick_t      now;
    logic       typed;
    key_event_t ev;
  } dir_row_t;

  // worst case: a queued report behind the one in the back end, then slack
  localparam int SETTLE_CYCLES = 3 * (STEPS + 2) + 20;
  localparam int DIR_ROWS      = 18;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 42;
  localparam logic TYPED       = 1'b1;
  localparam logic PREDICT     = 1'b0;
  // indexes past the two registers, written only to check they are ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_slot0_code;
  logic [7:0]           in_slot1_code;
  logic [7:0]           in_slot2_code;
  logic [7:0]           in_slot3_code;
  logic [7:0]           in_slot4_code;
  logic [7:0]           in_slot5_code;
  logic [31:0]          in_now_tick;
  logic                 out_valid;
  logic                 out_ready;
  logic [2:0]           out_event_kind;
  logic [7:0]           out_event_code;
  logic                 out_last_of_report;

  hid_report_key_event_generator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_slot0_code      (in_slot0_code),
    .in_slot1_code      (in_slot1_code),
    .in_slot2_code      (in_slot2_code),
    .in_slot3_code      (in_slot3_code),
    .in_slot4_code      (in_slot4_code),
    .in_slot5_code      (in_slot5_code),
    .in_now_tick        (in_now_tick),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_event_code     (out_event_code),
    .out_last_of_report (out_last_of_report)
  );

  // 100 MHz
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // key repeat state kept alongside the block
  ticks16_t   delay_reg;
  ticks16_t   rate_reg;
  code_t      prev_codes [SLOTS];
  tick_t      press_tick [SLOTS];
  ticks16_t   countdown  [SLOTS];
  code_t      sent_code  [SLOTS];

  key_event_t report_events [$];  // events of the report just accepted
  key_event_t events_due    [$];  // event words still owed by the block
  int         mismatches;

  // random sequence state
  code_t      held_keys [$];
  tick_t      tick_now;
  bit         steady_sender;

  dir_row_t   directed_tbl [DIR_ROWS];

  task automatic note_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void add_event(input event_kind_t kind, input code_t code);
    key_event_t ev;
    ev.kind = kind;
    ev.code = code;
    ev.last = 1'b0;
    report_events.push_back(ev);
  endfunction

  // events for one report, updating the per-slot repeat state
  function automatic void predict_report(input slots_t cur, input tick_t now);
    logic       rejected;
    logic       present;
    logic       seen;
    tick_t      elapsed;
    key_event_t ev;
    int         i;
    int         j;
    report_events.delete();
    rejected = 1'b0;
    // error report: only the first error slot speaks, state untouched
    for (i = 0; i < SLOTS && !rejected; i++) begin
      if (cur[i] == CODE_POST_FAIL) begin
        add_event(KIND_POST_FAIL, CODE_EMPTY);
        rejected = 1'b1;
      end else if (cur[i] == CODE_ROLLOVER) begin
        add_event(KIND_ROLLOVER, CODE_EMPTY);
        rejected = 1'b1;
      end
    end
    if (!rejected) begin
      // release / repeat pass over the old slots
      for (i = 0; i < SLOTS; i++) begin
        if (prev_codes[i] != CODE_EMPTY) begin
          present = 1'b0;
          for (j = 0; j < SLOTS; j++)
            if (cur[j] == prev_codes[i]) present = 1'b1;
          if (!present) begin
            add_event(KIND_UP, sent_code[i]);
          end else begin
            elapsed = now - press_tick[i];
            if (elapsed >= tick_t'(countdown[i])) begin
              add_event(KIND_HOLD, prev_codes[i]);
              sent_code[i]  = prev_codes[i];
              press_tick[i] = now;
              countdown[i]  = rate_reg;
            end
          end
        end
      end
      // press pass over the new slots, duplicates each count
      for (i = 0; i < SLOTS; i++) begin
        if (cur[i] != CODE_EMPTY) begin
          seen = 1'b0;
          for (j = 0; j < SLOTS; j++)
            if (prev_codes[j] == cur[i]) seen = 1'b1;
          if (!seen) begin
            countdown[i]  = delay_reg;
            add_event(KIND_DOWN, cur[i]);
            sent_code[i]  = cur[i];
            press_tick[i] = now;
          end
        end
      end
      for (i = 0; i < SLOTS; i++) prev_codes[i] = cur[i];
    end
    if (report_events.size() > 0) begin
      ev = report_events.pop_back();
      ev.last = 1'b1;
      report_events.push_back(ev);
    end
  endfunction

  function automatic dir_row_t row(input code_t s0, input code_t s1, input code_t s2,
                                   input code_t s3, input code_t s4, input code_t s5,
                                   input tick_t now, input logic typed,
                                   input event_kind_t kind, input code_t code);
    dir_row_t r;
    r.slots   = {s0, s1, s2, s3, s4, s5};
    r.now     = now;
    r.typed   = typed;
    r.ev.kind = kind;
    r.ev.code = code;
    r.ev.last = 1'b1;
    return r;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long hole
  function automatic int sender_gap();
    int r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // drive one report word and hold it until the block takes it
  task automatic send_report(input slots_t rep, input tick_t now, input logic typed,
                             input key_event_t typed_ev);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_slot0_code = rep[0];
    in_slot1_code = rep[1];
    in_slot2_code = rep[2];
    in_slot3_code = rep[3];
    in_slot4_code = rep[4];
    in_slot5_code = rep[5];
    in_now_tick   = now;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge
    predict_report(rep, now);
    if (typed) begin
      events_due.push_back(typed_ev);
    end else begin
      foreach (report_events[k]) events_due.push_back(report_events[k]);
    end
  endtask

  // sender stops until every owed event word has come out
  task automatic drain_events();
    @(negedge clk) in_valid = 1'b0;
    while (events_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input ticks16_t val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == CFG_HOLD_DELAY) delay_reg = val;
    else if (idx == CFG_HOLD_RATE) rate_reg = val;
    @(negedge clk) cfg_we = 1'b0;
  endtask

  // next report of a plausible typing session, with some noise and errors
  task automatic make_report(output slots_t rep);
    int    i;
    int    r;
    int    pos;
    code_t k;
    for (i = held_keys.size() - 1; i >= 0; i--)
      if ($urandom_range(0, 3) == 0) held_keys.delete(i);
    if (held_keys.size() < SLOTS && $urandom_range(0, 9) < 4) begin
      k = code_t'($urandom_range(3, 255));
      held_keys.push_back(k);
    end
    rep = '0;
    if ($urandom_range(0, 4) == 0) begin
      // keys land in scattered slots
      foreach (held_keys[h]) begin
        do pos = $urandom_range(0, SLOTS - 1); while (rep[pos] != CODE_EMPTY);
        rep[pos] = held_keys[h];
      end
    end else begin
      foreach (held_keys[h]) rep[h] = held_keys[h];
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      for (i = 0; i < SLOTS; i++) rep[i] = code_t'($urandom_range(0, 255));
    end else if (r < 11) begin
      pos = $urandom_range(0, SLOTS - 1);
      rep[pos] = $urandom_range(0, 1) ? CODE_ROLLOVER : CODE_POST_FAIL;
    end else if (r < 16 && held_keys.size() > 0 && held_keys.size() < SLOTS) begin
      // same key reported twice
      do pos = $urandom_range(0, SLOTS - 1); while (rep[pos] != CODE_EMPTY);
      rep[pos] = held_keys[0];
    end
    // ticks move forward, mostly slowly, now and then a jump anywhere
    r = $urandom_range(0, 99);
    if (r < 70) tick_now += $urandom_range(0, 80);
    else if (r < 90) tick_now += $urandom_range(0, 1000);
    else if (r < 97) tick_now += $urandom_range(0, 70000);
    else tick_now = $urandom;
  endtask

  // event word checker
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        note_mismatch($sformatf("event word with none owed: kind %0d code %02h last %0b",
                                out_event_kind, out_event_code, out_last_of_report));
      end else begin
        want = events_due.pop_front();
        if (out_event_kind !== want.kind)
          note_mismatch($sformatf("event_kind %0d, want %0d", out_event_kind, want.kind));
        if (out_event_code !== want.code)
          note_mismatch($sformatf("event_code %02h, want %02h", out_event_code, want.code));
        if (out_last_of_report !== want.last)
          note_mismatch($sformatf("last_of_report %0b, want %0b", out_last_of_report,
                                  want.last));
      end
    end
  end

  // receiver: runs of ready, short stalls mostly, long stalls sometimes
  initial begin
    int hi;
    int lo;
    int r;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      r  = $urandom_range(0, 99);
      hi = (r < 25) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      r  = $urandom_range(0, 99);
      if (r < 70) lo = $urandom_range(1, 2);
      else if (r < 95) lo = $urandom_range(3, 8);
      else lo = $urandom_range(20, 40);
      @(negedge clk) out_ready = 1'b1;
      repeat (hi - 1) @(negedge clk);
      @(negedge clk) out_ready = 1'b0;
      repeat (lo - 1) @(negedge clk);
    end
  end

  // hard stop, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("hid_report_key_event_generator verification failed");
    $finish;
  end

  // stimulus
  initial begin
    slots_t     rep;
    key_event_t none;
    int         p;
    int         n;
    int         i;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HOLD_DELAY;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_slot0_code = CODE_EMPTY;
    in_slot1_code = CODE_EMPTY;
    in_slot2_code = CODE_EMPTY;
    in_slot3_code = CODE_EMPTY;
    in_slot4_code = CODE_EMPTY;
    in_slot5_code = CODE_EMPTY;
    in_now_tick   = '0;
    mismatches    = 0;
    steady_sender = 1'b0;
    none          = '0;
    tick_now      = '0;

    delay_reg = 16'd500;
    rate_reg  = 16'd50;
    for (i = 0; i < SLOTS; i++) begin
      prev_codes[i] = CODE_EMPTY;
      press_tick[i] = '0;
      countdown[i]  = '0;
      sent_code[i]  = CODE_EMPTY;
    end

    // kind and code only matter on typed rows
    directed_tbl = '{
      // empty report right after reset: nothing
      row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0,   PREDICT, KIND_DOWN, 8'h00),
      row(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd10,  TYPED,   KIND_DOWN, 8'h04),
      // held but the initial delay has not run out
      row(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd100, PREDICT, KIND_DOWN, 8'h00),
      // exactly the initial delay, then exactly the repeat rate
      row(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd510, TYPED,   KIND_HOLD, 8'h04),
      row(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd560, TYPED,   KIND_HOLD, 8'h04),
      // error reports leave the state alone
      row(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 32'd600, TYPED,   KIND_ROLLOVER, 8'h00),
      row(8'h02, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 32'd610, TYPED,   KIND_POST_FAIL, 8'h00),
      // code 3 is an ordinary key, old key moves to another slot
      row(8'h03, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 32'd620, PREDICT, KIND_DOWN, 8'h00),
      // all ones everywhere: ups, then six downs of the same key
      row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, PREDICT, KIND_DOWN, 8'h00),
      // tick wraps to zero, everything released
      row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0,   PREDICT, KIND_DOWN, 8'h00),
      row(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFF_FF00, PREDICT, KIND_DOWN, 8'h00),
      // elapsed time across the wrap
      row(8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0100, PREDICT, KIND_DOWN, 8'h00),
      // same key moves into a slot with stale timing
      row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 32'h0000_0104, PREDICT, KIND_DOWN, 8'h00),
      row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 32'h0000_0105, PREDICT, KIND_DOWN, 8'h00),
      row(8'hAA, 8'h55, 8'hCC, 8'h33, 8'hF0, 8'h0F, 32'hAAAA_AAAA, PREDICT, KIND_DOWN, 8'h00),
      // first error slot wins
      row(8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 32'h5555_5555, TYPED, KIND_ROLLOVER, 8'h00),
      row(8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 32'h5555_5555, TYPED, KIND_POST_FAIL, 8'h00),
      row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h5555_5555, PREDICT, KIND_DOWN, 8'h00)
    };

    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed table with reset register values
    for (i = 0; i < DIR_ROWS; i++)
      send_report(directed_tbl[i].slots, directed_tbl[i].now, directed_tbl[i].typed,
                  directed_tbl[i].ev);

    // random typing sessions, one register setting per phase
    tick_now = 32'h5555_5555;
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        // block must be idle before touching the registers
        drain_events();
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (p)
          1: begin
            // every held key repeats on every report
            cfg_write(CFG_HOLD_DELAY, 16'h0000);
            cfg_write(CFG_HOLD_RATE, 16'h0000);
            cfg_write(CFG_SPARE_A, 16'hFFFF);
            cfg_write(CFG_SPARE_B, 16'h1234);
          end
          2: begin
            cfg_write(CFG_HOLD_DELAY, 16'hFFFF);
            cfg_write(CFG_HOLD_RATE, 16'hFFFF);
          end
          3: begin
            cfg_write(CFG_HOLD_DELAY, ticks16_t'($urandom_range(0, 600)));
            cfg_write(CFG_HOLD_RATE, ticks16_t'($urandom_range(0, 120)));
          end
          default: begin
            cfg_write(CFG_HOLD_DELAY, 16'h0001);
            cfg_write(CFG_HOLD_RATE, ticks16_t'($urandom_range(0, 65535)));
            cfg_write(CFG_SPARE_A, ticks16_t'($urandom_range(0, 65535)));
          end
        endcase
      end
      // one phase with no sender holes at all
      steady_sender = (p == 1);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits mid-phase for the block to run dry
        if (p == 2 && n == PHASE_ITEMS / 2) drain_events();
        make_report(rep);
        send_report(rep, tick_now, PREDICT, none);
      end
    end

    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("hid_report_key_event_generator verification clean");
    end else begin
      $display("hid_report_key_event_generator verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/hrkeg_pkg.sv
src/hrkeg_front.sv
src/hrkeg_queue.sv
src/hrkeg_back.sv
src/hid_report_key_event_generator.sv
tb/tb_hid_report_key_event_generator.sv
